// File: sv/rbfta_pkg.sv
// ----------------------------------------------------------------------------
// rbfta_pkg
// Types, constants and helpers shared by the force and torque accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package rbfta_pkg;

   localparam int KIND_W   = 2;
   localparam int OBJ_W    = 4;
   localparam int OBJ_EXT_W = 8;
   localparam int COORD_W  = 8;
   localparam int VAL_W    = 32;
   localparam int SUM_W    = 48;
   localparam int OFS_W    = 34;
   localparam int PROD_W   = OFS_W + VAL_W;
   localparam int FLOOR_W  = PROD_W - 16;
   localparam int TERM_W   = FLOOR_W + 1;
   localparam int WIDE_W   = 52;
   localparam int CENTER_ROW_W = 3 * VAL_W;
   localparam int SUM_ROW_W    = 6 * SUM_W;

   localparam logic signed [WIDE_W-1:0] SAT_HI = 52'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] SAT_LO = 52'shF_8000_0000_0000;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_CENTER = 2'd1,
      KIND_NODE   = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STEP_TX_POS = 3'd0,
      STEP_TX_NEG = 3'd1,
      STEP_TY_POS = 3'd2,
      STEP_TY_NEG = 3'd3,
      STEP_TZ_POS = 3'd4,
      STEP_TZ_NEG = 3'd5
   } step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RESPOND,
      ST_OFFSET,
      ST_MUL,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic     load;
      logic     clear;
      logic     center_wr;
      logic     offset_load;
      logic     mul_en;
      step_type mul_step;
      logic     sum_wr;
      logic     respond;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     obj_valid;
      logic     node_ok;
   } status_type;

   function automatic logic signed [SUM_W-1:0] sat48(input logic signed [WIDE_W-1:0] s);
      logic signed [SUM_W-1:0] r;
      if (s > SAT_HI) begin
         r = SAT_HI[SUM_W-1:0];
      end else if (s < SAT_LO) begin
         r = SAT_LO[SUM_W-1:0];
      end else begin
         r = s[SUM_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/rbfta_ram.sv
// ----------------------------------------------------------------------------
// rbfta_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbfta_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/rbfta_ctrl.sv
// ----------------------------------------------------------------------------
// rbfta_ctrl
// Sequencer: decodes the latched request and steps the datapath through
// offset, six shared multiplies and the saturating sum update.
// ----------------------------------------------------------------------------
`default_nettype none

module rbfta_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire rbfta_pkg::status_type  status,
   output rbfta_pkg::cmd_type          cmd
);

   import rbfta_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_TX_POS;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.mul_step = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.kind)
               KIND_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
               KIND_CENTER: begin
                  cmd.center_wr = status.obj_valid;
                  state_in      = ST_IDLE;
               end
               KIND_NODE: begin
                  state_in = status.node_ok ? ST_OFFSET : ST_IDLE;
               end
               KIND_READ: begin
                  state_in = ST_RESPOND;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_OFFSET: begin
            cmd.offset_load = 1'b1;
            step_in         = STEP_TX_POS;
            state_in        = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (step_ff == STEP_TZ_NEG) begin
               step_in  = STEP_TX_POS;
               state_in = ST_DRAIN;
            end else begin
               step_in = step_type'(step_ff + 3'd1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.sum_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// File: sv/rbfta_datapath.sv
// ----------------------------------------------------------------------------
// rbfta_datapath
// Request registers, center and sum memories, offset, shared multiplier,
// cross-product terms, saturating adders and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbfta_datapath #(
   parameter int MAX_OBJECTS  = 16,
   parameter int LATTICE_SIDE = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rbfta_pkg::cmd_type                    cmd,
   output rbfta_pkg::status_type                      status,
   input  wire logic [rbfta_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [rbfta_pkg::OBJ_W-1:0]           req_object_index,
   input  wire logic                                  req_is_solid,
   input  wire logic [rbfta_pkg::COORD_W-1:0]         req_node_x,
   input  wire logic [rbfta_pkg::COORD_W-1:0]         req_node_y,
   input  wire logic [rbfta_pkg::COORD_W-1:0]         req_node_z,
   input  wire logic signed [rbfta_pkg::VAL_W-1:0]    req_value_x,
   input  wire logic signed [rbfta_pkg::VAL_W-1:0]    req_value_y,
   input  wire logic signed [rbfta_pkg::VAL_W-1:0]    req_value_z,
   output logic                                       rsp_valid,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_force_x,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_force_y,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_force_z,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_torque_x,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_torque_y,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_torque_z
);

   import rbfta_pkg::*;

   localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

   // latched request
   logic [KIND_W-1:0]        kind_ff;
   logic [OBJ_W-1:0]         obj_ff;
   logic                     solid_ff;
   logic [COORD_W-1:0]       nx_ff, ny_ff, nz_ff;
   logic signed [VAL_W-1:0]  vx_ff, vy_ff, vz_ff;

   logic [OBJ_EXT_W-1:0]     obj_ext;
   logic [IDX_W-1:0]         addr;
   logic                     obj_valid;
   logic                     in_lattice;

   logic [MAX_OBJECTS-1:0]   sum_valid_ff;
   logic                     row_valid;

   logic [CENTER_ROW_W-1:0]  center_rd;
   logic [SUM_ROW_W-1:0]     sum_rd;
   logic [SUM_ROW_W-1:0]     sum_wr_data;

   logic signed [OFS_W-1:0]  r_ff [3];
   logic signed [SUM_W-1:0]  fsum_ff [3];
   logic signed [SUM_W-1:0]  tsum_ff [3];

   logic signed [OFS_W-1:0]  mul_a;
   logic signed [VAL_W-1:0]  mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   step_type                 prod_step_ff;
   logic                     prod_valid_ff;
   logic signed [FLOOR_W-1:0] prod_floor;
   logic signed [TERM_W-1:0] term_ff [3];
   logic signed [TERM_W-1:0] term_in [3];

   logic                     rsp_valid_ff;
   logic signed [SUM_W-1:0]  rsp_sum_ff [6];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         obj_ff   <= req_object_index;
         solid_ff <= req_is_solid;
         nx_ff    <= req_node_x;
         ny_ff    <= req_node_y;
         nz_ff    <= req_node_z;
         vx_ff    <= req_value_x;
         vy_ff    <= req_value_y;
         vz_ff    <= req_value_z;
      end
   end

   assign obj_ext    = {{(OBJ_EXT_W - OBJ_W){1'b0}}, obj_ff};
   assign addr       = obj_ext[IDX_W-1:0];
   assign obj_valid  = (32'(obj_ff) < MAX_OBJECTS);
   assign in_lattice = (32'(nx_ff) < LATTICE_SIDE) && (32'(ny_ff) < LATTICE_SIDE) &&
                       (32'(nz_ff) < LATTICE_SIDE);
   assign row_valid  = obj_valid && sum_valid_ff[addr];

   assign status.kind      = kind_type'(kind_ff);
   assign status.obj_valid = obj_valid;
   assign status.node_ok   = solid_ff && obj_valid && in_lattice;

   rbfta_ram #(
      .WIDTH (CENTER_ROW_W),
      .DEPTH (MAX_OBJECTS)
   ) u_center_ram (
      .clock   (clock),
      .wr_en   (cmd.center_wr),
      .wr_addr (addr),
      .wr_data ({vz_ff, vy_ff, vx_ff}),
      .rd_addr (addr),
      .rd_data (center_rd)
   );

   rbfta_ram #(
      .WIDTH (SUM_ROW_W),
      .DEPTH (MAX_OBJECTS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (cmd.sum_wr),
      .wr_addr (addr),
      .wr_data (sum_wr_data),
      .rd_addr (addr),
      .rd_data (sum_rd)
   );

   // row valid bits stand in for zeroing the sum memory
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         sum_valid_ff <= '0;
      end else if (cmd.sum_wr) begin
         sum_valid_ff[addr] <= 1'b1;
      end
   end

   // offsets r = node * 2^16 - center
   always_ff @(posedge clock) begin
      if (cmd.offset_load) begin
         r_ff[0] <= $signed({10'b0, nx_ff, 16'b0}) -
                    OFS_W'($signed(center_rd[VAL_W-1:0]));
         r_ff[1] <= $signed({10'b0, ny_ff, 16'b0}) -
                    OFS_W'($signed(center_rd[2*VAL_W-1:VAL_W]));
         r_ff[2] <= $signed({10'b0, nz_ff, 16'b0}) -
                    OFS_W'($signed(center_rd[3*VAL_W-1:2*VAL_W]));
         for (int j = 0; j < 3; j++) begin
            fsum_ff[j] <= row_valid ? $signed(sum_rd[j*SUM_W +: SUM_W]) : '0;
            tsum_ff[j] <= row_valid ? $signed(sum_rd[(3+j)*SUM_W +: SUM_W]) : '0;
         end
      end
   end

   always_comb begin
      case (cmd.mul_step)
         STEP_TX_POS: begin mul_a = r_ff[1]; mul_b = vz_ff; end
         STEP_TX_NEG: begin mul_a = r_ff[2]; mul_b = vy_ff; end
         STEP_TY_POS: begin mul_a = r_ff[2]; mul_b = vx_ff; end
         STEP_TY_NEG: begin mul_a = r_ff[0]; mul_b = vz_ff; end
         STEP_TZ_POS: begin mul_a = r_ff[0]; mul_b = vy_ff; end
         STEP_TZ_NEG: begin mul_a = r_ff[1]; mul_b = vx_ff; end
         default:     begin mul_a = '0;      mul_b = '0;    end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= cmd.mul_en;
      end
      if (cmd.mul_en) begin
         prod_ff      <= prod_in;
         prod_step_ff <= cmd.mul_step;
      end
   end

   // arithmetic shift right = floor
   assign prod_floor = prod_ff[PROD_W-1:16];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         term_in[j] = term_ff[j];
      end
      if (prod_valid_ff) begin
         case (prod_step_ff)
            STEP_TX_POS: term_in[0] = TERM_W'(prod_floor);
            STEP_TX_NEG: term_in[0] = term_ff[0] - TERM_W'(prod_floor);
            STEP_TY_POS: term_in[1] = TERM_W'(prod_floor);
            STEP_TY_NEG: term_in[1] = term_ff[1] - TERM_W'(prod_floor);
            STEP_TZ_POS: term_in[2] = TERM_W'(prod_floor);
            STEP_TZ_NEG: term_in[2] = term_ff[2] - TERM_W'(prod_floor);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         term_ff[j] <= term_in[j];
      end
   end

   always_comb begin
      sum_wr_data[SUM_W-1:0] =
         sat48(WIDE_W'(fsum_ff[0]) + WIDE_W'(vx_ff));
      sum_wr_data[2*SUM_W-1:SUM_W] =
         sat48(WIDE_W'(fsum_ff[1]) + WIDE_W'(vy_ff));
      sum_wr_data[3*SUM_W-1:2*SUM_W] =
         sat48(WIDE_W'(fsum_ff[2]) + WIDE_W'(vz_ff));
      for (int j = 0; j < 3; j++) begin
         sum_wr_data[(3+j)*SUM_W +: SUM_W] =
            sat48(WIDE_W'(tsum_ff[j]) + WIDE_W'(term_ff[j]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         for (int j = 0; j < 6; j++) begin
            rsp_sum_ff[j] <= row_valid ? $signed(sum_rd[j*SUM_W +: SUM_W]) : '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sum_force_x  = rsp_sum_ff[0];
   assign rsp_sum_force_y  = rsp_sum_ff[1];
   assign rsp_sum_force_z  = rsp_sum_ff[2];
   assign rsp_sum_torque_x = rsp_sum_ff[3];
   assign rsp_sum_torque_y = rsp_sum_ff[4];
   assign rsp_sum_torque_z = rsp_sum_ff[5];

endmodule

`default_nettype wire

// File: sv/rigid_body_force_torque_accumulator.sv
// Node request: busy through dispatch, offset, multiply, drain and update states;
//   the six cross-product terms go through one shared multiplier, one a cycle.
// Read request: busy through dispatch and respond; the response strobe is registered.
// Clear, set-center and skipped node requests: busy only for the dispatch state.
// Reset (synchronous): controller idle, all object sums zero, centers undefined.
// ----------------------------------------------------------------------------
// rigid_body_force_torque_accumulator
// Accumulates Q16.16 node forces and torques onto rigid objects, 48-bit
// saturating sums, read back one object at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_body_force_torque_accumulator #(
   parameter int MAX_OBJECTS  = 16,
   parameter int LATTICE_SIDE = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [rbfta_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [rbfta_pkg::OBJ_W-1:0]           req_object_index,
   input  wire logic                                  req_is_solid,
   input  wire logic [rbfta_pkg::COORD_W-1:0]         req_node_x,
   input  wire logic [rbfta_pkg::COORD_W-1:0]         req_node_y,
   input  wire logic [rbfta_pkg::COORD_W-1:0]         req_node_z,
   input  wire logic signed [rbfta_pkg::VAL_W-1:0]    req_value_x,
   input  wire logic signed [rbfta_pkg::VAL_W-1:0]    req_value_y,
   input  wire logic signed [rbfta_pkg::VAL_W-1:0]    req_value_z,
   output logic                                       rsp_valid,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_force_x,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_force_y,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_force_z,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_torque_x,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_torque_y,
   output logic signed [rbfta_pkg::SUM_W-1:0]         rsp_sum_torque_z
);

   import rbfta_pkg::*;

   cmd_type    cmd;
   status_type status;

   rbfta_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   rbfta_datapath #(
      .MAX_OBJECTS  (MAX_OBJECTS),
      .LATTICE_SIDE (LATTICE_SIDE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_object_index (req_object_index),
      .req_is_solid     (req_is_solid),
      .req_node_x       (req_node_x),
      .req_node_y       (req_node_y),
      .req_node_z       (req_node_z),
      .req_value_x      (req_value_x),
      .req_value_y      (req_value_y),
      .req_value_z      (req_value_z),
      .rsp_valid        (rsp_valid),
      .rsp_sum_force_x  (rsp_sum_force_x),
      .rsp_sum_force_y  (rsp_sum_force_y),
      .rsp_sum_force_z  (rsp_sum_force_z),
      .rsp_sum_torque_x (rsp_sum_torque_x),
      .rsp_sum_torque_y (rsp_sum_torque_y),
      .rsp_sum_torque_z (rsp_sum_torque_z)
   );

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives node, center, clear and read requests into the force and torque
// accumulator under varying sender gaps. A local body model predicts each
// read and every response is compared field by field.
// ----------------------------------------------------------------------------

module testbench;
   import rbfta_pkg::*;

   localparam int NUM_OBJECTS = 16;
   localparam longint SUM_TOP = 64'sd140737488355327;
   localparam longint SUM_BOT = -64'sd140737488355328;

   typedef struct {
      kind_type                  kind;
      logic [OBJ_W-1:0]          obj;
      logic                      solid;
      logic [COORD_W-1:0]        nx, ny, nz;
      logic signed [VAL_W-1:0]   vx, vy, vz;
   } body_request_type;

   typedef struct {
      logic signed [SUM_W-1:0] fx, fy, fz, tx, ty, tz;
   } body_sums_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic [KIND_W-1:0]         req_kind = '0;
   logic [OBJ_W-1:0]          req_object_index = '0;
   logic                      req_is_solid = 1'b0;
   logic [COORD_W-1:0]        req_node_x = '0;
   logic [COORD_W-1:0]        req_node_y = '0;
   logic [COORD_W-1:0]        req_node_z = '0;
   logic signed [VAL_W-1:0]   req_value_x = '0;
   logic signed [VAL_W-1:0]   req_value_y = '0;
   logic signed [VAL_W-1:0]   req_value_z = '0;
   logic                      busy;
   logic                      rsp_valid;
   logic signed [SUM_W-1:0]   rsp_sum_force_x, rsp_sum_force_y, rsp_sum_force_z;
   logic signed [SUM_W-1:0]   rsp_sum_torque_x, rsp_sum_torque_y, rsp_sum_torque_z;

   logic signed [VAL_W-1:0]   center_x [NUM_OBJECTS];
   logic signed [VAL_W-1:0]   center_y [NUM_OBJECTS];
   logic signed [VAL_W-1:0]   center_z [NUM_OBJECTS];
   logic signed [SUM_W-1:0]   force_total [NUM_OBJECTS][3];
   logic signed [SUM_W-1:0]   torque_total [NUM_OBJECTS][3];
   body_sums_type             expected_sums [$];
   int                        sender_idle_pct = 0;
   int                        error_count = 0;

   rigid_body_force_torque_accumulator dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_object_index (req_object_index),
      .req_is_solid     (req_is_solid),
      .req_node_x       (req_node_x),
      .req_node_y       (req_node_y),
      .req_node_z       (req_node_z),
      .req_value_x      (req_value_x),
      .req_value_y      (req_value_y),
      .req_value_z      (req_value_z),
      .rsp_valid        (rsp_valid),
      .rsp_sum_force_x  (rsp_sum_force_x),
      .rsp_sum_force_y  (rsp_sum_force_y),
      .rsp_sum_force_z  (rsp_sum_force_z),
      .rsp_sum_torque_x (rsp_sum_torque_x),
      .rsp_sum_torque_y (rsp_sum_torque_y),
      .rsp_sum_torque_z (rsp_sum_torque_z)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic logic signed [33:0] node_offset(input logic [COORD_W-1:0] c,
                                                      input logic signed [VAL_W-1:0] ctr);
      return 34'((longint'(c) <<< 16) - longint'(ctr));
   endfunction

   // exact Q34.32 product, floored to Q.16
   function automatic longint floored_product(input logic signed [33:0] r,
                                              input logic signed [VAL_W-1:0] f);
      logic signed [65:0] p;
      p = r * f;
      return longint'(p >>> 16);
   endfunction

   function automatic logic signed [SUM_W-1:0] add_saturated(input logic signed [SUM_W-1:0] acc,
                                                             input longint term);
      longint total;
      total = longint'(acc) + term;
      if (total > SUM_TOP) begin
         total = SUM_TOP;
      end else if (total < SUM_BOT) begin
         total = SUM_BOT;
      end
      return total[SUM_W-1:0];
   endfunction

   function automatic void update_body_model(input body_request_type rq);
      logic signed [33:0] rx, ry, rz;
      body_sums_type      s;
      int                 o;
      o = int'(rq.obj);
      case (rq.kind)
         KIND_CLEAR: begin
            for (int i = 0; i < NUM_OBJECTS; i++) begin
               for (int a = 0; a < 3; a++) begin
                  force_total[i][a] = '0;
                  torque_total[i][a] = '0;
               end
            end
         end
         KIND_CENTER: begin
            center_x[o] = rq.vx;
            center_y[o] = rq.vy;
            center_z[o] = rq.vz;
         end
         KIND_NODE: begin
            if (rq.solid) begin
               rx = node_offset(rq.nx, center_x[o]);
               ry = node_offset(rq.ny, center_y[o]);
               rz = node_offset(rq.nz, center_z[o]);
               force_total[o][0] = add_saturated(force_total[o][0], longint'(rq.vx));
               force_total[o][1] = add_saturated(force_total[o][1], longint'(rq.vy));
               force_total[o][2] = add_saturated(force_total[o][2], longint'(rq.vz));
               torque_total[o][0] = add_saturated(torque_total[o][0],
                  floored_product(ry, rq.vz) - floored_product(rz, rq.vy));
               torque_total[o][1] = add_saturated(torque_total[o][1],
                  floored_product(rz, rq.vx) - floored_product(rx, rq.vz));
               torque_total[o][2] = add_saturated(torque_total[o][2],
                  floored_product(rx, rq.vy) - floored_product(ry, rq.vx));
            end
         end
         KIND_READ: begin
            s.fx = force_total[o][0];
            s.fy = force_total[o][1];
            s.fz = force_total[o][2];
            s.tx = torque_total[o][0];
            s.ty = torque_total[o][1];
            s.tz = torque_total[o][2];
            expected_sums.push_back(s);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(7))
         0, 1: v = $urandom;
         2: begin
            case ($urandom_range(4))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = 32'sh0000_0000;
               3: v = 32'shFFFF_FFFF;
               default: v = 32'sh0000_0001;
            endcase
         end
         default: v = $signed($urandom_range(2097151)) - 32'sd1048576;
      endcase
      return v;
   endfunction

   function automatic body_request_type random_request(input kind_type k,
                                                       input logic [OBJ_W-1:0] o);
      body_request_type rq;
      rq.kind = k;
      rq.obj = o;
      rq.solid = 1'($urandom_range(1));
      rq.nx = COORD_W'($urandom_range(255));
      rq.ny = COORD_W'($urandom_range(255));
      rq.nz = COORD_W'($urandom_range(255));
      rq.vx = pick_value();
      rq.vy = pick_value();
      rq.vz = pick_value();
      return rq;
   endfunction

   task automatic send_request(input body_request_type rq);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_kind <= rq.kind;
      req_object_index <= rq.obj;
      req_is_solid <= rq.solid;
      req_node_x <= rq.nx;
      req_node_y <= rq.ny;
      req_node_z <= rq.nz;
      req_value_x <= rq.vx;
      req_value_y <= rq.vy;
      req_value_z <= rq.vz;
      // busy only moves on the rising edge, so it is stable here
      while (busy) begin
         @(negedge clock);
      end
      @(posedge clock);
      update_body_model(rq);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic signed [SUM_W-1:0] want,
                              input logic signed [SUM_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      body_sums_type s;
      if (!reset && rsp_valid) begin
         if (expected_sums.size() == 0) begin
            $error("unexpected response strobe");
            error_count++;
         end else begin
            s = expected_sums.pop_front();
            check_field("sum_force_x", s.fx, rsp_sum_force_x);
            check_field("sum_force_y", s.fy, rsp_sum_force_y);
            check_field("sum_force_z", s.fz, rsp_sum_force_z);
            check_field("sum_torque_x", s.tx, rsp_sum_torque_x);
            check_field("sum_torque_y", s.ty, rsp_sum_torque_y);
            check_field("sum_torque_z", s.tz, rsp_sum_torque_z);
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_values();
      send_request(random_request(KIND_READ, 4'd0));
      send_request(random_request(KIND_READ, 4'd15));
   endtask

   task automatic test_extreme_nodes();
      body_request_type rq;
      rq = random_request(KIND_CENTER, 4'd0);
      rq.vx = 32'sh7FFF_FFFF; rq.vy = 32'sh8000_0000; rq.vz = '0;
      send_request(rq);
      rq = random_request(KIND_CENTER, 4'd15);
      rq.vx = 32'sh8000_0000; rq.vy = 32'sh7FFF_FFFF; rq.vz = 32'shFFFF_FFFF;
      send_request(rq);
      rq = random_request(KIND_NODE, 4'd0);
      rq.solid = 1'b1; rq.nx = 8'd255; rq.ny = 8'd0; rq.nz = 8'd255;
      rq.vx = 32'sh7FFF_FFFF; rq.vy = 32'sh8000_0000; rq.vz = 32'sh7FFF_FFFF;
      send_request(rq);
      // fluid node must leave the sums alone
      rq = random_request(KIND_NODE, 4'd15);
      rq.solid = 1'b0; rq.vx = 32'sh7FFF_FFFF;
      send_request(rq);
      rq = random_request(KIND_NODE, 4'd15);
      rq.solid = 1'b1; rq.nx = 8'd0; rq.ny = 8'd255; rq.nz = 8'd0;
      rq.vx = 32'sh8000_0000; rq.vy = 32'sh7FFF_FFFF; rq.vz = 32'shFFFF_FFFF;
      send_request(rq);
      rq = random_request(KIND_NODE, 4'd0);
      rq.solid = 1'b1; rq.nx = 8'd0; rq.ny = 8'd255; rq.nz = 8'd0;
      rq.vx = 32'sh8000_0000; rq.vy = 32'sh8000_0000; rq.vz = 32'sh8000_0000;
      send_request(rq);
      send_request(random_request(KIND_READ, 4'd0));
      send_request(random_request(KIND_READ, 4'd15));
   endtask

   task automatic test_clear();
      send_request(random_request(KIND_CLEAR, 4'($urandom_range(15))));
      send_request(random_request(KIND_READ, 4'd0));
      send_request(random_request(KIND_READ, 4'd15));
   endtask

   task automatic test_random_traffic(input int count);
      body_request_type rq;
      int               pick;
      // every object gets a center before any node request touches it
      for (int o = 0; o < NUM_OBJECTS; o++) begin
         send_request(random_request(KIND_CENTER, 4'(o)));
      end
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            rq = random_request(KIND_CLEAR, 4'($urandom_range(15)));
         end else if (pick < 10) begin
            rq = random_request(KIND_CENTER, 4'($urandom_range(15)));
         end else if (pick < 75) begin
            rq = random_request(KIND_NODE, 4'($urandom_range(15)));
            rq.solid = ($urandom_range(9) != 0);
         end else begin
            rq = random_request(KIND_READ, 4'($urandom_range(15)));
         end
         send_request(rq);
      end
   endtask

   // full-scale forces far from the center drive the torque sums to both rails
   task automatic test_torque_saturation();
      body_request_type rq;
      rq = random_request(KIND_CENTER, 4'd9);
      rq.vx = 32'sh8000_0000; rq.vy = 32'sh8000_0000; rq.vz = 32'sh8000_0000;
      send_request(rq);
      send_request(random_request(KIND_CLEAR, 4'd0));
      for (int n = 0; n < 4; n++) begin
         rq = random_request(KIND_NODE, 4'd9);
         rq.solid = 1'b1; rq.nx = 8'd255; rq.ny = 8'd255; rq.nz = 8'd255;
         rq.vx = 32'sh7FFF_FFFF; rq.vy = 32'sh8000_0000; rq.vz = 32'sh7FFF_FFFF;
         send_request(rq);
      end
      send_request(random_request(KIND_READ, 4'd9));
      for (int n = 0; n < 4; n++) begin
         rq = random_request(KIND_NODE, 4'd9);
         rq.solid = 1'b1; rq.nx = 8'd255; rq.ny = 8'd255; rq.nz = 8'd255;
         rq.vx = 32'sh8000_0000; rq.vy = 32'sh7FFF_FFFF; rq.vz = 32'sh8000_0000;
         send_request(rq);
      end
      send_request(random_request(KIND_READ, 4'd9));
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      for (int o = 0; o < NUM_OBJECTS; o++) begin
         center_x[o] = '0;
         center_y[o] = '0;
         center_z[o] = '0;
         for (int a = 0; a < 3; a++) begin
            force_total[o][a] = '0;
            torque_total[o][a] = '0;
         end
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 6;
      test_reset_values();
      test_extreme_nodes();
      test_clear();
      test_random_traffic(180);

      sender_idle_pct = 79;
      test_random_traffic(180);

      sender_idle_pct = 0;
      test_random_traffic(180);
      test_torque_saturation();

      @(negedge clock);
      start <= 1'b0;
      while (expected_sums.size() != 0) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);
      if (expected_sums.size() != 0) begin
         $error("%0d responses never arrived", expected_sums.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
